### rtl/lba_pkg.sv
// Shared types and constants for the linked block allocator.
package lba_pkg;

   localparam int BLOCK_COUNT = 32768;
   localparam int MAX_FILES   = 256;
   localparam int BLK_W       = $clog2(BLOCK_COUNT);
   localparam int CNT_W       = BLK_W + 1;
   localparam int FID_W       = $clog2(MAX_FILES);

   localparam logic [CNT_W-1:0] END_MARK   = '1;
   localparam logic [16:0]      BS_RESET   = 17'd1024;
   localparam logic [14:0]      RSV_RESET  = 15'd128;

   localparam logic CSR_BLOCK_SIZE = 1'b0;
   localparam logic CSR_RESERVED   = 1'b1;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_EXTEND = 2'd1,
      OP_SHRINK = 2'd2,
      OP_ACCESS = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  file_id;
      logic [30:0] amount;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic [14:0] block_index;
      logic [15:0] free_blocks;
   } rsp_item_type;

   typedef struct packed {
      logic [BLK_W-1:0] start;
      logic [CNT_W-1:0] blocks;
      logic [31:0]      bytes;
   } dir_entry_type;

   typedef struct packed {
      logic        done;
      logic [30:0] quot;
      logic        rem_nz;
   } div_res_type;

endpackage

### rtl/lba_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lba_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [30:0]        dividend,
   input  logic [16:0]        divisor,
   output lba_pkg::div_res_type res
);
   import lba_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] dvd_ff, dvd_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] div_ff, div_in;
   logic [17:0] sh;
   logic        ge;

   always_comb begin
      sh      = {rem_ff, dvd_ff[30]};
      ge      = sh >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 17'(sh - {1'b0, div_ff}) : sh[16:0];
         dvd_in = {dvd_ff[29:0], ge};
         cnt_in = 5'(cnt_ff + 5'd1);
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res.done   = done_ff;
   assign res.quot   = dvd_ff;
   assign res.rem_nz = rem_ff != '0;

endmodule

### rtl/linked_block_allocator.sv
// Top level: sequencer, allocation table memories and directory of the allocator.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_item  (req_type, file_id, amount)
//  rsp     | out       | rsp_valid/stall    | rsp_item  (status, block_index, free_blocks)
//  csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One item at a time. Create and access run the serial divider; every chain step
// waits on a link memory read, and every block looked at while claiming waits on
// a used-map read. After reset the used map is cleared, one block a cycle, with
// req_stall high. A stalled rsp holds the result; the next item is still taken.
module linked_block_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lba_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lba_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [16:0]           csr_data
);
   import lba_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIR, ST_DIV_WAIT, ST_CHECK, ST_WALK_RD, ST_WALK_CHK,
      ST_GRAB_RD, ST_GRAB_CHK, ST_FREE_RD, ST_FREE_CHK, ST_LINK_END, ST_MUL,
      ST_FIN, ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [BLK_W-1:0] clr_ff, clr_in;
   op_type           op_ff, op_in;
   logic [FID_W-1:0] fid_ff, fid_in;
   logic [30:0]      amt_ff, amt_in;
   logic [CNT_W-1:0] nb_ff, nb_in;
   logic [31:0]      bytes_ff, bytes_in;
   logic [BLK_W-1:0] start_ff, start_in;
   logic             dv_ff, dv_in;
   logic [31:0]      ceil_ff, ceil_in;
   logic [BLK_W-1:0] cur_ff, cur_in;
   logic [BLK_W-1:0] prev_ff, prev_in;
   logic             hp_ff, hp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] alloc_ff, alloc_in;
   logic [32:0]      prod_ff, prod_in;
   logic             status_ff, status_in;
   logic [BLK_W-1:0] where_ff, where_in;
   logic [16:0]      bs_ff, bs_in;
   logic [14:0]      rsv_ff, rsv_in;
   logic [MAX_FILES-1:0] dvalid_ff, dvalid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   // memories
   logic [CNT_W-1:0]  link_mem [0:BLOCK_COUNT-1];
   logic              used_mem [0:BLOCK_COUNT-1];
   dir_entry_type     dir_mem  [0:MAX_FILES-1];
   logic [CNT_W-1:0]  link_q;
   logic              used_q;
   dir_entry_type     dir_q;

   logic              link_we, used_we, used_wd, dir_we;
   logic [BLK_W-1:0]  link_wa, link_ra, used_wa, used_ra;
   logic [CNT_W-1:0]  link_wd;
   dir_entry_type     dir_wd;

   logic [16:0]       bs_eff;
   logic [CNT_W-1:0]  usable, free_cnt;
   logic [BLK_W-1:0]  follow;
   logic [31:0]       steps;
   logic [33:0]       grown;
   div_res_type       div_res;
   logic              div_go;

   lba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (amt_ff),
      .divisor  (bs_eff),
      .res      (div_res)
   );

   assign bs_eff   = (bs_ff == '0) ? 17'd1 : bs_ff;
   assign usable   = CNT_W'(BLOCK_COUNT) - {1'b0, rsv_ff};
   assign free_cnt = (alloc_ff >= usable) ? '0 : CNT_W'(usable - alloc_ff);
   assign follow   = link_q[CNT_W-1] ? cur_ff : link_q[BLK_W-1:0];
   assign div_go   = (state_ff == ST_DIR) && (op_ff == OP_CREATE || op_ff == OP_ACCESS);
   assign grown    = {2'b0, bytes_ff} + {1'b0, prod_ff};

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in  = state_ff;  clr_in   = clr_ff;   op_in    = op_ff;
      fid_in    = fid_ff;    amt_in   = amt_ff;   nb_in    = nb_ff;
      bytes_in  = bytes_ff;  start_in = start_ff; dv_in    = dv_ff;
      ceil_in   = ceil_ff;   cur_in   = cur_ff;   prev_in  = prev_ff;
      hp_in     = hp_ff;     cnt_in   = cnt_ff;   scan_in  = scan_ff;
      alloc_in  = alloc_ff;  prod_in  = prod_ff;  status_in = status_ff;
      where_in  = where_ff;  bs_in    = bs_ff;    rsv_in   = rsv_ff;
      dvalid_in = dvalid_ff; rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      link_we = 1'b0; link_wa = prev_ff; link_wd = END_MARK; link_ra = cur_ff;
      used_we = 1'b0; used_wa = clr_ff;  used_wd = 1'b0;     used_ra = scan_ff[BLK_W-1:0];
      dir_we  = 1'b0; dir_wd  = '0;
      steps   = '0;

      if (csr_valid) begin
         if (csr_index == CSR_BLOCK_SIZE) bs_in = csr_data;
         else                             rsv_in = csr_data[14:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            used_we = 1'b1;
            clr_in  = BLK_W'(clr_ff + 1'b1);
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_item.req_type);
               fid_in   = req_item.file_id;
               amt_in   = req_item.amount;
               dv_in    = dvalid_ff[req_item.file_id];
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            nb_in     = dv_ff ? dir_q.blocks : '0;
            bytes_in  = dv_ff ? dir_q.bytes  : '0;
            start_in  = dir_q.start;
            status_in = 1'b1;
            where_in  = '0;
            state_in  = div_go ? ST_DIV_WAIT : ST_CHECK;
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               ceil_in  = {1'b0, div_res.quot} + 32'(div_res.rem_nz);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
            cur_in   = start_ff;
            scan_in  = {1'b0, rsv_ff};
            hp_in    = 1'b0;
            case (op_ff)
               OP_CREATE: begin
                  if (nb_ff == '0 && ceil_ff <= 32'(free_cnt)) begin
                     status_in = 1'b0;
                     cnt_in    = ceil_ff[CNT_W-1:0];
                     state_in  = (ceil_ff == '0) ? ST_DONE : ST_GRAB_RD;
                  end
               end
               OP_EXTEND: begin
                  if (nb_ff != '0 && amt_ff <= 31'(free_cnt)) begin
                     status_in = 1'b0;
                     cnt_in    = CNT_W'(nb_ff - 1'b1);
                     state_in  = ST_WALK_RD;
                  end
               end
               OP_SHRINK: begin
                  if (nb_ff != '0 && amt_ff <= 31'(nb_ff - 1'b1)) begin
                     status_in = 1'b0;
                     cnt_in    = CNT_W'(nb_ff - amt_ff[CNT_W-1:0] - 1'b1);
                     state_in  = ST_WALK_RD;
                  end
               end
               default: begin
                  if (nb_ff != '0 && bytes_ff != '0 && {1'b0, amt_ff} <= bytes_ff) begin
                     status_in = 1'b0;
                     steps = (ceil_ff == '0) ? '0 : 32'(ceil_ff - 1'b1);
                     if (steps > 32'(nb_ff - 1'b1)) steps = 32'(nb_ff - 1'b1);
                     cnt_in   = steps[CNT_W-1:0];
                     state_in = ST_WALK_RD;
                  end
               end
            endcase
         end
         ST_WALK_RD: begin
            if (cnt_ff == '0) begin
               case (op_ff)
                  OP_EXTEND: begin
                     prev_in  = cur_ff;
                     hp_in    = 1'b1;
                     cnt_in   = amt_ff[CNT_W-1:0];
                     state_in = ST_GRAB_RD;
                  end
                  OP_SHRINK: begin
                     prev_in  = cur_ff;
                     cnt_in   = amt_ff[CNT_W-1:0];
                     state_in = ST_FREE_RD;
                  end
                  default: begin
                     where_in = cur_ff;
                     state_in = ST_DONE;
                  end
               endcase
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            cur_in   = follow;
            cnt_in   = CNT_W'(cnt_ff - 1'b1);
            state_in = ST_WALK_RD;
         end
         ST_GRAB_RD: begin
            if (cnt_ff == '0 || scan_ff[CNT_W-1]) state_in = ST_LINK_END;
            else                                  state_in = ST_GRAB_CHK;
         end
         ST_GRAB_CHK: begin
            if (!used_q) begin
               used_we  = 1'b1;
               used_wa  = scan_ff[BLK_W-1:0];
               used_wd  = 1'b1;
               link_we  = hp_ff;
               link_wd  = scan_ff;
               if (!hp_ff) start_in = scan_ff[BLK_W-1:0];
               prev_in  = scan_ff[BLK_W-1:0];
               hp_in    = 1'b1;
               alloc_in = CNT_W'(alloc_ff + 1'b1);
               cnt_in   = CNT_W'(cnt_ff - 1'b1);
            end
            scan_in  = CNT_W'(scan_ff + 1'b1);
            state_in = ST_GRAB_RD;
         end
         ST_FREE_RD: begin
            state_in = (cnt_ff == '0) ? ST_LINK_END : ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            used_we  = 1'b1;
            used_wa  = follow;
            cur_in   = follow;
            if (alloc_ff != '0) alloc_in = CNT_W'(alloc_ff - 1'b1);
            cnt_in   = CNT_W'(cnt_ff - 1'b1);
            state_in = ST_FREE_RD;
         end
         ST_LINK_END: begin
            link_we  = 1'b1;
            state_in = (op_ff == OP_CREATE) ? ST_FIN : ST_MUL;
         end
         ST_MUL: begin
            prod_in  = amt_ff[CNT_W-1:0] * bs_eff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            dir_we       = 1'b1;
            dir_wd.start = start_ff;
            case (op_ff)
               OP_CREATE: begin
                  dir_wd.blocks = ceil_ff[CNT_W-1:0];
                  dir_wd.bytes  = {1'b0, amt_ff};
               end
               OP_EXTEND: begin
                  dir_wd.blocks = CNT_W'(nb_ff + amt_ff[CNT_W-1:0]);
                  dir_wd.bytes  = (grown[33:32] != 2'b0) ? '1 : grown[31:0];
               end
               default: begin
                  dir_wd.blocks = CNT_W'(nb_ff - amt_ff[CNT_W-1:0]);
                  dir_wd.bytes  = (prod_ff >= {1'b0, bytes_ff}) ? '0 :
                                  32'(bytes_ff - prod_ff[31:0]);
               end
            endcase
            dvalid_in[fid_ff] = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.block_index = where_ff;
               rsp_in.free_blocks = free_cnt;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_FREE_RD || state_ff == ST_WALK_RD) link_ra = cur_ff;
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_q <= link_mem[link_ra];
      if (used_we) used_mem[used_wa] <= used_wd;
      used_q <= used_mem[used_ra];
      if (dir_we) dir_mem[fid_ff] <= dir_wd;
      dir_q <= dir_mem[fid_in];
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;     fid_ff   <= fid_in;   amt_ff   <= amt_in;
      nb_ff     <= nb_in;     bytes_ff <= bytes_in; start_ff <= start_in;
      dv_ff     <= dv_in;     ceil_ff  <= ceil_in;  cur_ff   <= cur_in;
      prev_ff   <= prev_in;   hp_ff    <= hp_in;    cnt_ff   <= cnt_in;
      scan_ff   <= scan_in;   prod_ff  <= prod_in;  status_ff <= status_in;
      where_ff  <= where_in;  rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         alloc_ff     <= '0;
         bs_ff        <= BS_RESET;
         rsv_ff       <= RSV_RESET;
         dvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_ff     <= alloc_in;
         bs_ff        <= bs_in;
         rsv_ff       <= rsv_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= CNT_W'(BLOCK_COUNT))
      else $error("allocated count beyond block count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && $past(state_ff == ST_DIV_WAIT)) |-> $past(div_res.done))
      else $error("check entered before divider finished");

endmodule
